@@ rtl/dasr_pkg.sv @@
// Shared types and constants for the dual-axis speed ramp PD motor drive.
`default_nettype none

package dasr_pkg;

    // Gyro rate scaling and drive saturation.
    localparam int unsigned GYRO_DIVISOR = 5700;
    localparam int unsigned PWM_LIMIT    = 32767;

    // floor(2^32 / divisor); the quotient it gives is exact or one low.
    localparam logic [32:0] C_GYRO_RECIP = 33'((64'd1 << 32) / 64'(GYRO_DIVISOR));
    localparam logic [15:0] C_GYRO_DIV   = 16'(GYRO_DIVISOR);

    localparam logic signed [35:0] C_PWM_MAX = 36'(PWM_LIMIT);
    localparam logic signed [35:0] C_PWM_MIN = -36'(PWM_LIMIT);

    localparam logic signed [43:0] C_ACC_MAX = 44'sd2147483647;
    localparam logic signed [43:0] C_ACC_MIN = -44'sd2147483648;

    // Pipeline depth, input register through output register.
    localparam int C_NUM_STAGES = 10;

    // Configuration register map (byte address = 4 * index).
    typedef enum logic [2:0] {
        REG_ACCEL_X = 3'd0,
        REG_DECEL_X = 3'd1,
        REG_ACCEL_W = 3'd2,
        REG_DECEL_W = 3'd3,
        REG_PGAIN_X = 3'd4,
        REG_DGAIN_X = 3'd5,
        REG_PGAIN_W = 3'd6,
        REG_DGAIN_W = 3'd7
    } t_reg_idx;

    localparam logic [15:0] C_RST_ACCEL_X = 16'd256;
    localparam logic [15:0] C_RST_DECEL_X = 16'd256;
    localparam logic [15:0] C_RST_ACCEL_W = 16'd256;
    localparam logic [15:0] C_RST_DECEL_W = 16'd256;
    localparam logic [15:0] C_RST_PGAIN_X = 16'd512;
    localparam logic [15:0] C_RST_DGAIN_X = 16'd1024;
    localparam logic [15:0] C_RST_PGAIN_W = 16'd256;
    localparam logic [15:0] C_RST_DGAIN_W = 16'd3072;

    // Rotational feedback source; the unused code behaves as FB_BOTH.
    typedef enum logic [1:0] {
        FB_BOTH = 2'd0,
        FB_GYRO = 2'd1,
        FB_ENC  = 2'd2
    } t_fb_mode;

endpackage

`default_nettype wire

@@ rtl/dual_axis_speed_ramp_pd_motor_drive.sv @@
// Top level: encoder differencing, speed ramps, PD error loops and PWM mixing.
//
// Usage:
//  - Input channel (i_valid / o_stall) carries one control tick: raw encoder
//    counts, gyro rate, x/w target speeds and the feedback mode. A transaction
//    is taken on a clock edge with i_valid high and o_stall low.
//  - Output channel (o_valid / i_stall) returns one result per tick: left and
//    right PWM, travel count and the ramped x/w speeds, in tick order.
//  - APB port holds eight 16-bit registers (ramp steps, PD gains) at 4*index;
//    write them only while no tick is in flight. pready is tied high.
//  - Throughput: one tick per cycle while the output is not stalled, set by
//    the ten-stage pipeline; the divide-by-constant for the gyro (reciprocal
//    multiply, back-multiply, correct) and the PD multipliers each own their
//    stages.
//  - Per-tick state (previous raw counts, ramps, running totals, error
//    accumulators) is updated as the tick passes the stage that owns it, so
//    consecutive ticks chain correctly through the pipe.
//  - Reset (synchronous, active low) empties the pipe, zeroes all per-tick state and
//    loads register defaults.
//  - When i_stall holds the output, stages keep advancing into empty slots;
//    o_stall rises only when every stage is full.
`default_nettype none

module dual_axis_speed_ramp_pd_motor_drive
    import dasr_pkg::*;
(
    input  wire                i_clk,
    input  wire                i_rst_n,

    // input ticks
    input  wire                i_valid,
    output logic               o_stall,
    input  wire         [15:0] i_left_enc_raw,
    input  wire         [15:0] i_right_enc_raw,
    input  wire  signed [31:0] i_gyro_rate,
    input  wire  signed [15:0] i_target_speed_x,
    input  wire  signed [15:0] i_target_speed_w,
    input  wire         [1:0]  i_feedback_mode,

    // results
    output logic               o_valid,
    input  wire                i_stall,
    output logic signed [15:0] o_left_pwm,
    output logic signed [15:0] o_right_pwm,
    output logic signed [31:0] o_travel_count,
    output logic signed [23:0] o_speed_now_x,
    output logic signed [23:0] o_speed_now_w,

    // configuration
    input  wire                psel,
    input  wire                penable,
    input  wire                pwrite,
    input  wire         [4:0]  paddr,
    input  wire         [31:0] pwdata,
    output logic        [31:0] prdata,
    output logic               pready
);

    // ------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------
    // Step cur toward tgt, never passing it.
    function automatic logic signed [23:0] f_ramp(
        input logic signed [23:0] cur,
        input logic signed [23:0] tgt,
        input logic        [15:0] up,
        input logic        [15:0] dn
    );
        logic signed [25:0] c;
        logic signed [25:0] t;
        c = 26'(cur);
        t = 26'(tgt);
        if (c < t) begin
            c = c + $signed({10'b0, up});
            if (c > t) c = t;
        end else if (c > t) begin
            c = c - $signed({10'b0, dn});
            if (c < t) c = t;
        end
        return c[23:0];
    endfunction

    function automatic logic signed [31:0] f_sat32(input logic signed [43:0] v);
        logic signed [43:0] s;
        s = v;
        if (v > C_ACC_MAX) s = C_ACC_MAX;
        else if (v < C_ACC_MIN) s = C_ACC_MIN;
        return s[31:0];
    endfunction

    function automatic logic signed [15:0] f_pwm_sat(input logic signed [35:0] v);
        logic signed [35:0] s;
        s = v;
        if (v > C_PWM_MAX) s = C_PWM_MAX;
        else if (v < C_PWM_MIN) s = C_PWM_MIN;
        return s[15:0];
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [15:0] r_cfg [8];
    logic        c_cfg_wr;

    assign pready   = 1'b1;
    assign c_cfg_wr = psel && penable && pwrite && pready;
    assign prdata   = {16'b0, r_cfg[paddr[4:2]]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg[REG_ACCEL_X] <= C_RST_ACCEL_X;
            r_cfg[REG_DECEL_X] <= C_RST_DECEL_X;
            r_cfg[REG_ACCEL_W] <= C_RST_ACCEL_W;
            r_cfg[REG_DECEL_W] <= C_RST_DECEL_W;
            r_cfg[REG_PGAIN_X] <= C_RST_PGAIN_X;
            r_cfg[REG_DGAIN_X] <= C_RST_DGAIN_X;
            r_cfg[REG_PGAIN_W] <= C_RST_PGAIN_W;
            r_cfg[REG_DGAIN_W] <= C_RST_DGAIN_W;
        end else if (c_cfg_wr) begin
            r_cfg[paddr[4:2]] <= pwdata[15:0];
        end
    end

    // ------------------------------------------------------------------
    // Pipeline flow control: a stage loads when it is empty or its item
    // moves on; bubbles collapse while the output is stalled.
    // ------------------------------------------------------------------
    logic [C_NUM_STAGES:1] r_vld;
    logic [C_NUM_STAGES:1] n_vld;
    logic [C_NUM_STAGES:1] c_take;
    logic [C_NUM_STAGES:1] c_ld;

    always_comb begin
        c_take[C_NUM_STAGES] = !r_vld[C_NUM_STAGES] || !i_stall;
        for (int k = C_NUM_STAGES - 1; k >= 1; k--) begin
            c_take[k] = !r_vld[k] || c_take[k+1];
        end
        c_ld[1]  = i_valid && c_take[1];
        n_vld[1] = c_take[1] ? i_valid : r_vld[1];
        for (int k = 2; k <= C_NUM_STAGES; k++) begin
            c_ld[k]  = r_vld[k-1] && c_take[k];
            n_vld[k] = c_take[k] ? r_vld[k-1] : r_vld[k];
        end
    end

    assign o_stall = !c_take[1];
    assign o_valid = r_vld[C_NUM_STAGES];

    // ------------------------------------------------------------------
    // Stage 1: encoder deltas, gyro magnitude, speed ramps
    // ------------------------------------------------------------------
    logic        [15:0] r_prev_l;
    logic        [15:0] r_prev_r;
    logic signed [23:0] r_ramp_x;
    logic signed [23:0] r_ramp_w;
    logic signed [23:0] n_ramp_x;
    logic signed [23:0] n_ramp_w;
    logic signed [23:0] c_tgt_x;
    logic signed [23:0] c_tgt_w;
    logic        [31:0] c_gyro_mag;

    assign c_tgt_x    = {i_target_speed_x, 8'h00};
    assign c_tgt_w    = {i_target_speed_w, 8'h00};
    assign n_ramp_x   = f_ramp(r_ramp_x, c_tgt_x, r_cfg[REG_ACCEL_X], r_cfg[REG_DECEL_X]);
    assign n_ramp_w   = f_ramp(r_ramp_w, c_tgt_w, r_cfg[REG_ACCEL_W], r_cfg[REG_DECEL_W]);
    assign c_gyro_mag = i_gyro_rate[31] ? 32'(-i_gyro_rate) : 32'(i_gyro_rate);

    logic signed [15:0] r1_dl, r1_dr;
    logic        [31:0] r1_mag;
    logic               r1_neg;
    t_fb_mode           r1_mode;
    logic signed [23:0] r1_sx, r1_sw;

    // ------------------------------------------------------------------
    // Stage 2: reciprocal multiply, running totals
    // ------------------------------------------------------------------
    logic        [64:0] c_recip_prod;
    logic        [31:0] r_ltot, r_rtot;
    logic        [31:0] n_ltot, n_rtot;

    assign c_recip_prod = {1'b0, r1_mag, 32'b0} >> 32;
    logic        [64:0] c_gq_full;
    assign c_gq_full = {33'b0, r1_mag} * {32'b0, C_GYRO_RECIP};
    assign n_ltot = r_ltot + 32'(r1_dl);
    assign n_rtot = r_rtot + 32'(r1_dr);

    logic        [31:0] r2_q0;
    logic        [31:0] r2_mag;
    logic               r2_neg;
    logic signed [15:0] r2_dl, r2_dr;
    t_fb_mode           r2_mode;
    logic signed [23:0] r2_sx, r2_sw;
    logic signed [31:0] r2_ltot, r2_rtot;

    // ------------------------------------------------------------------
    // Stage 3: back-multiply of the estimate, travel mean
    // ------------------------------------------------------------------
    logic        [47:0] c_back_prod;
    logic signed [32:0] c_tsum;
    logic signed [32:0] c_thalf;

    assign c_back_prod = {16'b0, r2_q0} * {32'b0, C_GYRO_DIV};
    assign c_tsum      = 33'(r2_ltot) + 33'(r2_rtot);
    // add one to negative sums so the halving truncates toward zero
    assign c_thalf     = c_tsum + $signed({32'b0, c_tsum[32]});

    logic        [31:0] r3_q0;
    logic        [31:0] r3_prod;
    logic        [31:0] r3_mag;
    logic               r3_neg;
    logic signed [15:0] r3_dl, r3_dr;
    t_fb_mode           r3_mode;
    logic signed [23:0] r3_sx, r3_sw;
    logic signed [31:0] r3_travel;

    // ------------------------------------------------------------------
    // Stage 4: quotient correction, signed gyro feedback, encoder differences and sums
    // ------------------------------------------------------------------
    logic        [31:0] c_rem;
    logic        [32:0] c_q;
    logic signed [32:0] c_gfb;

    assign c_rem = r3_mag - r3_prod;
    assign c_q   = {1'b0, r3_q0} + {32'b0, (c_rem >= {16'b0, C_GYRO_DIV})};
    assign c_gfb = r3_neg ? -$signed(c_q) : $signed(c_q);

    logic signed [32:0] r4_gfb;
    logic signed [16:0] r4_fbx;
    logic signed [16:0] r4_dlr;
    t_fb_mode           r4_mode;
    logic signed [23:0] r4_sx, r4_sw;
    logic signed [31:0] r4_travel;

    // ------------------------------------------------------------------
    // Stage 5: error accumulators (saturating)
    // ------------------------------------------------------------------
    logic signed [31:0] r_acc_x, r_acc_w;
    logic signed [31:0] n_acc_x, n_acc_w;
    logic signed [33:0] c_fbw;
    logic signed [43:0] c_fbx_sh, c_fbw_sh;

    always_comb begin
        unique case (r4_mode)
            FB_GYRO: c_fbw = 34'(r4_gfb);
            FB_ENC:  c_fbw = 34'(r4_dlr);
            default: c_fbw = 34'(r4_dlr) + 34'(r4_gfb);
        endcase
    end

    assign c_fbx_sh = 44'(r4_fbx) <<< 8;
    assign c_fbw_sh = 44'(c_fbw) <<< 8;
    assign n_acc_x  = f_sat32(44'(r_acc_x) + 44'(r4_sx) - c_fbx_sh);
    assign n_acc_w  = f_sat32(44'(r_acc_w) + 44'(r4_sw) - c_fbw_sh);

    logic signed [31:0] r5_ex, r5_ew;
    logic signed [31:0] r5_lx, r5_lw;
    logic signed [23:0] r5_sx, r5_sw;
    logic signed [31:0] r5_travel;

    // ------------------------------------------------------------------
    // Stage 6: error differences
    // ------------------------------------------------------------------
    logic signed [31:0] r6_ex, r6_ew;
    logic signed [32:0] r6_dx, r6_dw;
    logic signed [23:0] r6_sx, r6_sw;
    logic signed [31:0] r6_travel;

    // ------------------------------------------------------------------
    // Stage 7: PD products
    // ------------------------------------------------------------------
    logic signed [48:0] r7_ppx, r7_ppw;
    logic signed [49:0] r7_pdx, r7_pdw;
    logic signed [23:0] r7_sx, r7_sw;
    logic signed [31:0] r7_travel;

    // ------------------------------------------------------------------
    // Stage 8: PD sums
    // ------------------------------------------------------------------
    logic signed [50:0] r8_sumx, r8_sumw;
    logic signed [23:0] r8_sx, r8_sw;
    logic signed [31:0] r8_travel;

    // ------------------------------------------------------------------
    // Stage 9: divide by 65536, truncating toward zero
    // ------------------------------------------------------------------
    logic signed [50:0] c_rndx, c_rndw;

    assign c_rndx = r8_sumx + $signed({35'b0, {16{r8_sumx[50]}}});
    assign c_rndw = r8_sumw + $signed({35'b0, {16{r8_sumw[50]}}});

    logic signed [34:0] r9_px, r9_pw;
    logic signed [23:0] r9_sx, r9_sw;
    logic signed [31:0] r9_travel;

    // ------------------------------------------------------------------
    // Stage 10: mix axes and saturate into the output register
    // ------------------------------------------------------------------
    logic signed [15:0] r_out_l, r_out_r;
    logic signed [31:0] r_out_travel;
    logic signed [23:0] r_out_sx, r_out_sw;

    assign o_left_pwm     = r_out_l;
    assign o_right_pwm    = r_out_r;
    assign o_travel_count = r_out_travel;
    assign o_speed_now_x  = r_out_sx;
    assign o_speed_now_w  = r_out_sw;

    // ------------------------------------------------------------------
    // Control and per-tick state
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_prev_l <= '0;
            r_prev_r <= '0;
            r_ramp_x <= '0;
            r_ramp_w <= '0;
            r_ltot   <= '0;
            r_rtot   <= '0;
            r_acc_x  <= '0;
            r_acc_w  <= '0;
        end else begin
            r_vld <= n_vld;
            if (c_ld[1]) begin
                r_prev_l <= i_left_enc_raw;
                r_prev_r <= i_right_enc_raw;
                r_ramp_x <= n_ramp_x;
                r_ramp_w <= n_ramp_w;
            end
            if (c_ld[2]) begin
                r_ltot <= n_ltot;
                r_rtot <= n_rtot;
            end
            if (c_ld[5]) begin
                r_acc_x <= n_acc_x;
                r_acc_w <= n_acc_w;
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload registers (no reset)
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (c_ld[1]) begin
            r1_dl   <= $signed(i_left_enc_raw - r_prev_l);
            r1_dr   <= $signed(i_right_enc_raw - r_prev_r);
            r1_mag  <= c_gyro_mag;
            r1_neg  <= i_gyro_rate[31];
            r1_mode <= t_fb_mode'(i_feedback_mode);
            r1_sx   <= n_ramp_x;
            r1_sw   <= n_ramp_w;
        end
        if (c_ld[2]) begin
            r2_q0   <= c_gq_full[63:32];
            r2_mag  <= c_recip_prod[31:0];
            r2_neg  <= r1_neg;
            r2_dl   <= r1_dl;
            r2_dr   <= r1_dr;
            r2_mode <= r1_mode;
            r2_sx   <= r1_sx;
            r2_sw   <= r1_sw;
            r2_ltot <= $signed(n_ltot);
            r2_rtot <= $signed(n_rtot);
        end
        if (c_ld[3]) begin
            r3_q0     <= r2_q0;
            r3_prod   <= c_back_prod[31:0];
            r3_mag    <= r2_mag;
            r3_neg    <= r2_neg;
            r3_dl     <= r2_dl;
            r3_dr     <= r2_dr;
            r3_mode   <= r2_mode;
            r3_sx     <= r2_sx;
            r3_sw     <= r2_sw;
            r3_travel <= c_thalf[32:1];
        end
        if (c_ld[4]) begin
            r4_gfb    <= c_gfb;
            r4_fbx    <= 17'(r3_dl) + 17'(r3_dr);
            r4_dlr    <= 17'(r3_dr) - 17'(r3_dl);
            r4_mode   <= r3_mode;
            r4_sx     <= r3_sx;
            r4_sw     <= r3_sw;
            r4_travel <= r3_travel;
        end
        if (c_ld[5]) begin
            r5_ex     <= n_acc_x;
            r5_ew     <= n_acc_w;
            r5_lx     <= r_acc_x;
            r5_lw     <= r_acc_w;
            r5_sx     <= r4_sx;
            r5_sw     <= r4_sw;
            r5_travel <= r4_travel;
        end
        if (c_ld[6]) begin
            r6_ex     <= r5_ex;
            r6_ew     <= r5_ew;
            r6_dx     <= 33'(r5_ex) - 33'(r5_lx);
            r6_dw     <= 33'(r5_ew) - 33'(r5_lw);
            r6_sx     <= r5_sx;
            r6_sw     <= r5_sw;
            r6_travel <= r5_travel;
        end
        if (c_ld[7]) begin
            r7_ppx    <= $signed({1'b0, r_cfg[REG_PGAIN_X]}) * r6_ex;
            r7_ppw    <= $signed({1'b0, r_cfg[REG_PGAIN_W]}) * r6_ew;
            r7_pdx    <= $signed({1'b0, r_cfg[REG_DGAIN_X]}) * r6_dx;
            r7_pdw    <= $signed({1'b0, r_cfg[REG_DGAIN_W]}) * r6_dw;
            r7_sx     <= r6_sx;
            r7_sw     <= r6_sw;
            r7_travel <= r6_travel;
        end
        if (c_ld[8]) begin
            r8_sumx   <= 51'(r7_ppx) + 51'(r7_pdx);
            r8_sumw   <= 51'(r7_ppw) + 51'(r7_pdw);
            r8_sx     <= r7_sx;
            r8_sw     <= r7_sw;
            r8_travel <= r7_travel;
        end
        if (c_ld[9]) begin
            r9_px     <= c_rndx[50:16];
            r9_pw     <= c_rndw[50:16];
            r9_sx     <= r8_sx;
            r9_sw     <= r8_sw;
            r9_travel <= r8_travel;
        end
        if (c_ld[10]) begin
            r_out_l      <= f_pwm_sat(36'(r9_px) - 36'(r9_pw));
            r_out_r      <= f_pwm_sat(36'(r9_px) + 36'(r9_pw));
            r_out_travel <= r9_travel;
            r_out_sx     <= r9_sx;
            r_out_sw     <= r9_sw;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
`ifndef ASSERT_OFF
    // input side backs up only when the whole pipe is full behind a stall
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall && (&r_vld)))
        else $error("input stalled with an empty stage");

    // accelerating ramp never overshoots its target
    a_ramp_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (c_ld[1] && (c_tgt_x > r_ramp_x))
        |=> (r_ramp_x <= $past(c_tgt_x)) && (r_ramp_x >= $past(r_ramp_x)))
        else $error("x ramp passed target");

    // reciprocal estimate is exact or one low
    a_gyro_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[3] |-> ({1'b0, c_rem} < {16'b0, C_GYRO_DIV, 1'b0}))
        else $error("gyro quotient estimate off by more than one");

    // tick state moves only with an accepted tick
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !c_ld[1] |=> $stable(r_ramp_x) && $stable(r_ramp_w) && $stable(r_prev_l))
        else $error("tick state changed without a tick");

    // delivered drive stays within the PWM limit
    a_pwm_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (36'(o_left_pwm) <= C_PWM_MAX) && (36'(o_left_pwm) >= C_PWM_MIN)
                 && (36'(o_right_pwm) <= C_PWM_MAX) && (36'(o_right_pwm) >= C_PWM_MIN))
        else $error("pwm out of range");
`endif

endmodule

`default_nettype wire
